/* design/lspq_pkg.sv */
// ----------------------------------------------------------------------------
// lspq_pkg: shared types for the linear scan priority queue
// Word formats, status codes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
package lspq_pkg;

  localparam int DATA_W        = 32;
  localparam int PRIO_IN_W     = 16;
  localparam int FILL_W        = 7;
  localparam int CAPACITY_DEF  = 64;
  localparam int PRIO_BITS_DEF = 16;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_e;

  // input word
  typedef struct packed {
    op_e                         op;
    logic signed [DATA_W-1:0]    item_data;
    logic        [PRIO_IN_W-1:0] item_priority;
  } in_t;

  // result word
  typedef struct packed {
    status_e                     status;
    logic signed [DATA_W-1:0]    out_data;
    logic        [PRIO_IN_W-1:0] out_priority;
    logic        [FILL_W-1:0]    fill_count;
  } out_t;

endpackage

/* design/linear_scan_priority_queue.sv */
// ----------------------------------------------------------------------------
// linear_scan_priority_queue: bounded priority queue with linear scan dequeue
// Entries are kept in arrival order in one RAM. A dequeue scans all entries
// through a single comparator and then shifts later entries down one slot.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_word_i) takes one command word:
//   enqueue (data, priority) or dequeue the highest priority entry. Every
//   command gives exactly one result word on the output channel
//   (out_valid_o / out_ready_i / out_word_o) with status, dequeued data and
//   priority, and the fill count after the command.
//   Enqueue, full or empty cases go from the idle state to the done state,
//   which loads the output register; the next command is taken back in idle.
//   A dequeue of n stored entries with the best at slot b scans all n entries
//   with one RAM read per cycle, then shifts the entries above slot b with one
//   read and one write per cycle. The single RAM read port sets this pace.
//   One command is in work at a time.
//   The result sits in an output register; the next command is accepted while
//   it waits. If the receiver stalls, a finished command holds in the done
//   state until the output register frees up.
//   Reset empties the queue at once (count to zero); RAM contents are not
//   cleared, since only written slots are ever read.
// ----------------------------------------------------------------------------
module linear_scan_priority_queue #(
  parameter int CAPACITY      = lspq_pkg::CAPACITY_DEF,
  parameter int PRIORITY_BITS = lspq_pkg::PRIO_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  lspq_pkg::in_t  in_word_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output lspq_pkg::out_t out_word_o
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PB = PRIORITY_BITS;
  localparam int DW = lspq_pkg::DATA_W;

  // entry storage
  logic [DW-1:0] data_mem [CAPACITY];
  logic [PB-1:0] prio_mem [CAPACITY];

  lspq_pkg::state_e  state_q, state_d;
  lspq_pkg::status_e status_q;
  logic [CW-1:0]     count_q;
  logic [CW-1:0]     issue_q;
  logic              rdv_q;
  logic [CW-1:0]     rdi_q;
  logic [DW-1:0]     rd_data_q;
  logic [PB-1:0]     rd_prio_q;
  logic [DW-1:0]     best_data_q;
  logic [PB-1:0]     best_prio_q;
  logic [CW-1:0]     best_idx_q;
  logic              out_valid_q;
  lspq_pkg::out_t    out_q;

  logic          in_acc;
  logic          rd_en;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;
  logic [PB-1:0] wr_prio;
  logic          seq_end;
  logic          out_load;
  logic [CW-1:0] rdi_dec;

  assign in_acc   = in_valid_i && in_ready_o;
  assign seq_end  = (issue_q == count_q) && !rdv_q;
  assign out_load = (state_q == lspq_pkg::S_DONE) && (!out_valid_q || out_ready_i);
  assign rdi_dec  = rdi_q - CW'(1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lspq_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_word_i.op == lspq_pkg::OP_DEQ && count_q != '0) begin
            state_d = lspq_pkg::S_SCAN;
          end else begin
            state_d = lspq_pkg::S_DONE;
          end
        end
      end
      lspq_pkg::S_SCAN: begin
        if (seq_end) state_d = lspq_pkg::S_SHIFT;
      end
      lspq_pkg::S_SHIFT: begin
        if (seq_end) state_d = lspq_pkg::S_DONE;
      end
      lspq_pkg::S_DONE: begin
        if (out_load) state_d = lspq_pkg::S_IDLE;
      end
      default: state_d = lspq_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs: handshake and RAM control
  always_comb begin
    in_ready_o = 1'b0;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = rdi_dec[AW-1:0];
    wr_data    = rd_data_q;
    wr_prio    = rd_prio_q;
    unique case (state_q)
      lspq_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        wr_addr    = count_q[AW-1:0];
        wr_data    = in_word_i.item_data;
        wr_prio    = PB'(in_word_i.item_priority);
        wr_en      = in_acc && (in_word_i.op == lspq_pkg::OP_ENQ) &&
                     (count_q < CW'(CAPACITY));
      end
      lspq_pkg::S_SCAN: begin
        rd_en = issue_q < count_q;
      end
      lspq_pkg::S_SHIFT: begin
        rd_en = issue_q < count_q;
        wr_en = rdv_q;
      end
      lspq_pkg::S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // RAM: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      data_mem[wr_addr] <= wr_data;
      prio_mem[wr_addr] <= wr_prio;
    end
    if (rd_en) begin
      rd_data_q <= data_mem[issue_q[AW-1:0]];
      rd_prio_q <= prio_mem[issue_q[AW-1:0]];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lspq_pkg::S_IDLE;
      count_q     <= '0;
      rdv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rdv_q   <= rd_en;
      if (wr_en && state_q == lspq_pkg::S_IDLE) count_q <= count_q + CW'(1);
      if (state_q == lspq_pkg::S_SHIFT && seq_end) count_q <= count_q - CW'(1);
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath: scan compare, counters, result word
  always_ff @(posedge clk_i) begin
    if (rd_en) issue_q <= issue_q + CW'(1);
    rdi_q <= issue_q;
    unique case (state_q)
      lspq_pkg::S_IDLE: begin
        if (in_acc) begin
          issue_q     <= '0;
          best_data_q <= '0;
          best_prio_q <= '0;
          best_idx_q  <= '0;
          if (in_word_i.op == lspq_pkg::OP_ENQ) begin
            status_q <= (count_q < CW'(CAPACITY)) ? lspq_pkg::ST_DONE
                                                   : lspq_pkg::ST_FULL;
          end else begin
            status_q <= (count_q != '0) ? lspq_pkg::ST_DONE : lspq_pkg::ST_EMPTY;
          end
        end
      end
      lspq_pkg::S_SCAN: begin
        // first entry seeds the best; later ones win only when strictly greater
        if (rdv_q && (rdi_q == '0 || rd_prio_q > best_prio_q)) begin
          best_data_q <= rd_data_q;
          best_prio_q <= rd_prio_q;
          best_idx_q  <= rdi_q;
        end
        if (seq_end) issue_q <= best_idx_q + CW'(1);
      end
      lspq_pkg::S_SHIFT: begin
      end
      lspq_pkg::S_DONE: begin
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_q.status       <= status_q;
      out_q.out_data     <= best_data_q;
      out_q.out_priority <= lspq_pkg::PRIO_IN_W'(best_prio_q);
      out_q.fill_count   <= lspq_pkg::FILL_W'(count_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`ifndef SYNTHESIS
  // stored count never exceeds the capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // a finished dequeue removes exactly one entry
  a_deq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lspq_pkg::S_SHIFT && seq_end) |=> count_q == $past(count_q) - CW'(1))
    else $error("dequeue did not remove one entry");

  // shift writes stay inside the stored list
  a_shift_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lspq_pkg::S_SHIFT && wr_en) |-> (rdi_q != '0 && rdi_q < count_q))
    else $error("shift write outside stored entries");

  // full and empty reports agree with the fill count
  a_full_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.status == lspq_pkg::ST_FULL) |->
      out_word_o.fill_count == lspq_pkg::FILL_W'(CAPACITY))
    else $error("full status with queue not full");

  a_empty_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.status == lspq_pkg::ST_EMPTY) |->
      out_word_o.fill_count == '0)
    else $error("empty status with entries stored");
`endif

endmodule
